/* design/gf256_arithmetic_unit_top_macros.svh */
// Assertion macros shared by the GF(2^8) arithmetic unit RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef GF256_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define GF256_ARITHMETIC_UNIT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define GFAU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define GFAU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GFAU_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define GFAU_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

/* design/gfau_pkg.sv */
// Package for the GF(2^8) arithmetic unit: operation codes, control
// structs, reset polynomial and the degree function. No dependencies.
`default_nettype none
package gfau_pkg;

    // operation selector carried in tuser
    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_MUL = 2'd1,
        FUNC_INV = 2'd2,
        FUNC_QUO = 2'd3
    } func_t;

    // low byte of x^8 + x^4 + x^3 + x + 1
    localparam logic [7:0] POLY_RESET = 8'h1B;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } gfau_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
    } gfau_status_t;

    // degree of a 9-bit polynomial; meaningless for zero
    function automatic logic [3:0] deg9(input logic [8:0] p);
        logic [3:0] d;
        d = 4'd0;
        for (int i = 0; i < 9; i++) begin
            if (p[i]) begin
                d = 4'(i);
            end
        end
        return d;
    endfunction

endpackage
`default_nettype wire

/* design/gfau_ctrl.sv */
// Controller for the GF(2^8) arithmetic unit: accept, iterate, publish.
// Depends on gfau_pkg and the assertion macro header.
`default_nettype none
`include "gf256_arithmetic_unit_top_macros.svh"
module gfau_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output gfau_pkg::gfau_cmd_t        cmd,
    input  wire gfau_pkg::gfau_status_t status
);
    import gfau_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // output register can take a new word this cycle
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                cmd.step = 1'b1;
                if (status.done) begin
                    if (out_free) begin
                        cmd.publish    = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end else begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `GFAU_ASSERT_NXT(a_accept_runs, aclk, aresetn, s_tvalid && s_tready, state_reg == S_RUN, "accepted word did not start a run")
    `GFAU_ASSERT_IMP(a_wait_full, aclk, aresetn, state_reg == S_WAIT, out_valid_reg, "waiting with an empty output register")
    `GFAU_ASSERT_IMP(a_publish_free, aclk, aresetn, cmd.publish, out_free, "result overwrote an untaken word")
    `GFAU_ASSERT_NXT(a_publish_valid, aclk, aresetn, cmd.publish, m_tvalid, "published result not shown")

endmodule
`default_nettype wire

/* design/gfau_dp.sv */
// Datapath for the GF(2^8) arithmetic unit: polynomial register, operand
// registers, shift-add multiply, Euclid inverse, long division, result register.
// Depends on gfau_pkg and the assertion macro header.
`default_nettype none
`include "gf256_arithmetic_unit_top_macros.svh"
module gfau_dp (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr,
    input  wire logic [7:0]            cfg_data,
    input  wire logic [1:0]            in_func,
    input  wire logic [7:0]            in_a,
    input  wire logic [7:0]            in_b,
    input  wire gfau_pkg::gfau_cmd_t   cmd,
    output gfau_pkg::gfau_status_t     status,
    output logic [7:0]                 result,
    output logic                       divide_by_zero
);
    import gfau_pkg::*;

    logic [7:0] poly_reg;
    func_t      func_reg, func_next;
    logic [7:0] a_reg, a_next, b_reg, b_next;
    // multiply
    logic [7:0] acc_reg, acc_next, ma_reg, ma_next, mb_reg, mb_next;
    // inverse
    logic [8:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [7:0] t0_reg, t0_next, t1_reg, t1_next;
    // quotient
    logic [7:0] num_reg, num_next, q_reg, q_next;
    logic [2:0] db_reg, db_next;
    logic [3:0] qcnt_reg, qcnt_next;
    // output word
    logic [7:0] result_reg, result_next;
    logic       dz_reg, dz_next;

    logic       done;
    logic [3:0] d0, d1, sh, db_load;
    logic       swap;
    logic [2:0] qidx, qpos;

    // Euclid step terms
    assign d0   = deg9(r0_reg);
    assign d1   = deg9(r1_reg);
    assign swap = (r0_reg == 9'd0) || (d0 < d1);
    assign sh   = d0 - d1;

    // long division step terms
    assign qidx    = 3'(qcnt_reg - 4'd1);
    assign qpos    = db_reg + qidx;
    assign db_load = deg9({1'b0, in_b});

    // completion per operation
    always_comb begin
        unique case (func_reg)
            FUNC_ADD: done = 1'b1;
            FUNC_MUL: done = (mb_reg == 8'd0);
            FUNC_INV: done = (r1_reg == 9'd0);
            FUNC_QUO: done = (b_reg == 8'd0) || (qcnt_reg == 4'd0);
            default:  done = 1'b1;
        endcase
    end
    assign status.done = done;

    // next values
    always_comb begin
        func_next   = func_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        r0_next     = r0_reg;
        r1_next     = r1_reg;
        t0_next     = t0_reg;
        t1_next     = t1_reg;
        num_next    = num_reg;
        q_next      = q_reg;
        db_next     = db_reg;
        qcnt_next   = qcnt_reg;
        result_next = result_reg;
        dz_next     = dz_reg;

        if (cmd.load) begin
            func_next = func_t'(in_func);
            a_next    = in_a;
            b_next    = in_b;
            acc_next  = 8'd0;
            ma_next   = in_a;
            mb_next   = in_b;
            r0_next   = {1'b1, poly_reg};
            r1_next   = {1'b0, in_a};
            t0_next   = 8'd0;
            t1_next   = 8'd1;
            num_next  = in_a;
            q_next    = 8'd0;
            db_next   = db_load[2:0];
            qcnt_next = 4'd8 - {1'b0, db_load[2:0]};
        end else if (cmd.step && !done) begin
            unique case (func_reg)
                FUNC_MUL: begin
                    if (mb_reg[0]) begin
                        acc_next = acc_reg ^ ma_reg;
                    end
                    ma_next = {ma_reg[6:0], 1'b0} ^ (ma_reg[7] ? poly_reg : 8'd0);
                    mb_next = {1'b0, mb_reg[7:1]};
                end
                FUNC_INV: begin
                    if (swap) begin
                        r0_next = r1_reg;
                        r1_next = r0_reg;
                        t0_next = t1_reg;
                        t1_next = t0_reg;
                    end else begin
                        r0_next = r0_reg ^ (r1_reg << sh);
                        t0_next = t0_reg ^ (t1_reg << sh);
                    end
                end
                FUNC_QUO: begin
                    if (num_reg[qpos]) begin
                        num_next     = num_reg ^ (b_reg << qidx);
                        q_next[qidx] = 1'b1;
                    end
                    qcnt_next = qcnt_reg - 4'd1;
                end
                default: begin
                end
            endcase
        end

        // result selection into the output register
        if (cmd.publish) begin
            dz_next = 1'b0;
            unique case (func_reg)
                FUNC_ADD: result_next = a_reg ^ b_reg;
                FUNC_MUL: result_next = acc_reg;
                FUNC_INV: result_next = (r0_reg == 9'd1) ? t0_reg : 8'd0;
                FUNC_QUO: begin
                    if (b_reg == 8'd0) begin
                        result_next = 8'd0;
                        dz_next     = 1'b1;
                    end else begin
                        result_next = q_reg;
                    end
                end
                default: result_next = 8'd0;
            endcase
        end
    end

    // polynomial register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= POLY_RESET;
        end else if (cfg_wr) begin
            poly_reg <= cfg_data;
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_reg <= 8'd0;
            dz_reg     <= 1'b0;
        end else begin
            result_reg <= result_next;
            dz_reg     <= dz_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        num_reg  <= num_next;
        q_reg    <= q_next;
        db_reg   <= db_next;
        qcnt_reg <= qcnt_next;
    end

    assign result         = result_reg;
    assign divide_by_zero = dz_reg;

    `GFAU_ASSERT_IMP(a_dz_zero, aclk, aresetn, dz_reg, result_reg == 8'd0, "divide by zero with nonzero result")
    `GFAU_ASSERT_NXT(a_dz_quo, aclk, aresetn, cmd.publish && (func_reg != FUNC_QUO), !dz_reg, "divide by zero outside quotient")

endmodule
`default_nettype wire

/* design/gf256_arithmetic_unit_top.sv */
// GF(2^8) arithmetic unit: add, multiply, inverse and polynomial quotient
// with a programmable reduction polynomial (x^8 implied). One word is worked
// at a time; a new word is taken once the previous one has finished, even
// while its result still waits on the output. After acceptance the selected
// operation iterates before its result word is published: add needs no
// step, multiply one per bit of operand_b up to its highest set bit
// (at most 8), quotient 8 - deg(operand_b) (at most 8, none for a zero
// divisor), and inverse one per Euclid swap or reduction step; the Euclid
// loop in the datapath sets the worst case. The inverse of 0, or of an element
// sharing a factor with a reducible polynomial, is 0. A zero divisor gives
// result 0 with divide_by_zero set. Write cfg_data only while idle.
// Depends on gfau_pkg, gfau_ctrl and gfau_dp.
`default_nettype none
module gf256_arithmetic_unit_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] operand_a, [15:8] operand_b
    input  wire logic [1:0]  s_tuser,   // [1:0] func
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] result
    output logic [0:0]       m_tuser,   // [0] divide_by_zero
    // polynomial register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // [7:0] field_polynomial
);
    import gfau_pkg::*;

    gfau_cmd_t    cmd;
    gfau_status_t status;

    assign cfg_ready = 1'b1;

    gfau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    gfau_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .in_func        (s_tuser),
        .in_a           (s_tdata[7:0]),
        .in_b           (s_tdata[15:8]),
        .cmd            (cmd),
        .status         (status),
        .result         (m_tdata),
        .divide_by_zero (m_tuser[0])
    );

endmodule
`default_nettype wire
